/* design/rmbs_pkg.sv */
// shared constants, payload types and codes of the rate monotonic scheduler
package rmbs_pkg;

  localparam int MAX_TASKS  = 8;
  localparam int APER_DEPTH = 16;
  localparam int TIME_BITS  = 16;
  localparam int PEND_W     = 24;
  localparam int TASK_W     = $clog2(MAX_TASKS);
  localparam int TCNT_W     = $clog2(MAX_TASKS + 1);
  localparam int QPTR_W     = $clog2(APER_DEPTH);
  localparam int QCNT_W     = $clog2(APER_DEPTH + 1);
  localparam int ACT_W      = 4;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_LOAD   = 2'd1;
  localparam logic [1:0] REQ_SUBMIT = 2'd2;

  localparam logic [1:0] RAN_IDLE = 2'd0;
  localparam logic [1:0] RAN_PER  = 2'd1;
  localparam logic [1:0] RAN_APER = 2'd2;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_ORDER = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  task_slot;
    logic [15:0] period_ticks;
    logic [15:0] work_ticks;
    logic [15:0] deadline_ticks;
    logic [15:0] arrival_tick;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  ran_kind;
    logic [3:0]  ran_slot;
    logic        late_flag;
    logic [15:0] tick_now;
    logic [1:0]  error_code;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_LOAD,
    OP_SUBMIT,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  task_slot;
    logic [15:0] period_ticks;
    logic [15:0] work_ticks;
    logic [15:0] deadline_ticks;
    logic [15:0] arrival_tick;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RUN,
    S_REL,
    S_OUT
  } state_t;

endpackage

/* design/rmbs_front.sv */
// front end: two-word input queue that decodes each request into a command
module rmbs_front import rmbs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  in_word_t in_word,
  input  logic     push,
  output logic     full,
  output cmd_t     cmd,
  output logic     cmd_vld,
  input  logic     cmd_take
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;
  cmd_t       dec;

  always_comb begin
    dec.task_slot      = in_word.task_slot;
    dec.period_ticks   = in_word.period_ticks;
    dec.work_ticks     = in_word.work_ticks;
    dec.deadline_ticks = in_word.deadline_ticks;
    dec.arrival_tick   = in_word.arrival_tick;
    unique case (in_word.req_type)
      REQ_TICK:   dec.op = OP_TICK;
      REQ_LOAD:   dec.op = OP_LOAD;
      REQ_SUBMIT: dec.op = OP_SUBMIT;
      default:    dec.op = OP_NONE;
    endcase
  end

  assign full    = (cnt_r == 2'd2);
  assign cmd_vld = (cnt_r != 2'd0);
  assign cmd     = q_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = cmd_take && cmd_vld;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

/* design/rmbs_back.sv */
// back end: executes loads, submits and ticks, holds the task table and job queue
module rmbs_back import rmbs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  logic             cmd_vld,
  output logic             cmd_take,
  input  logic [ACT_W-1:0] active_tasks,
  output out_word_t        res_word,
  output logic             res_vld,
  input  logic             res_pop
);

  state_t                 state_r, state_nxt;
  op_t                    op_r, op_nxt;
  logic [TCNT_W-1:0]      idx_r, idx_nxt;
  logic [TASK_W-1:0]      best_r, best_nxt;
  logic [TIME_BITS-1:0]   best_per_r, best_per_nxt;
  logic                   found_r, found_nxt;
  out_word_t              res_r, res_nxt;
  out_word_t              out_r, out_nxt;
  logic                   out_vld_r, out_vld_nxt;
  logic [TIME_BITS-1:0]   tick_r, tick_nxt;

  logic [TIME_BITS-1:0]   period_r [MAX_TASKS];
  logic [TIME_BITS-1:0]   work_r [MAX_TASKS];
  logic [TIME_BITS-1:0]   dl_r [MAX_TASKS];
  logic [PEND_W-1:0]      pend_r [MAX_TASKS];
  logic [TIME_BITS-1:0]   phase_r [MAX_TASKS];
  logic [TIME_BITS-1:0]   period_nxt [MAX_TASKS];
  logic [TIME_BITS-1:0]   work_nxt [MAX_TASKS];
  logic [TIME_BITS-1:0]   dl_nxt [MAX_TASKS];
  logic [PEND_W-1:0]      pend_nxt [MAX_TASKS];
  logic [TIME_BITS-1:0]   phase_nxt [MAX_TASKS];

  logic [QPTR_W-1:0]      head_r, head_nxt;
  logic [QCNT_W-1:0]      qcnt_r, qcnt_nxt;
  logic [TIME_BITS-1:0]   last_arr_r, last_arr_nxt;

  // job queue memory, read at the head only
  logic [TIME_BITS-1:0]   arr_mem [APER_DEPTH];
  logic [TIME_BITS-1:0]   rem_mem [APER_DEPTH];
  logic [TIME_BITS-1:0]   rd_arr_r, rd_rem_r;
  logic                   arr_we, rem_we;
  logic [QPTR_W-1:0]      arr_addr, rem_addr;
  logic [TIME_BITS-1:0]   arr_wd, rem_wd;

  logic [TCNT_W-1:0]      n_act;
  logic [TASK_W-1:0]      ti;
  logic [TIME_BITS:0]     ph_inc;
  logic [PEND_W-1:0]      pend_dec;
  logic [PEND_W:0]        pend_sum;
  logic                   last_idx;

  assign n_act = (32'(active_tasks) > MAX_TASKS) ? TCNT_W'(MAX_TASKS)
                                                 : TCNT_W'(active_tasks);
  assign ti       = idx_r[TASK_W-1:0];
  assign last_idx = (idx_r == n_act - TCNT_W'(1));
  assign res_word = out_r;
  assign res_vld  = out_vld_r;

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    idx_nxt      = idx_r;
    best_nxt     = best_r;
    best_per_nxt = best_per_r;
    found_nxt    = found_r;
    res_nxt      = res_r;
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r && !res_pop;
    tick_nxt     = tick_r;
    period_nxt   = period_r;
    work_nxt     = work_r;
    dl_nxt       = dl_r;
    pend_nxt     = pend_r;
    phase_nxt    = phase_r;
    head_nxt     = head_r;
    qcnt_nxt     = qcnt_r;
    last_arr_nxt = last_arr_r;
    cmd_take     = 1'b0;
    arr_we       = 1'b0;
    rem_we       = 1'b0;
    arr_addr     = head_r + qcnt_r[QPTR_W-1:0];
    rem_addr     = head_r + qcnt_r[QPTR_W-1:0];
    arr_wd       = cmd.arrival_tick;
    rem_wd       = cmd.work_ticks;
    ph_inc       = {1'b0, phase_r[ti]} + (TIME_BITS+1)'(1);
    pend_dec     = pend_r[best_r] - PEND_W'(1);
    pend_sum     = {1'b0, pend_r[ti]} + (PEND_W+1)'(work_r[ti]);

    unique case (state_r)
      S_IDLE: begin
        if (cmd_vld) begin
          cmd_take = 1'b0;
          cmd_take = 1'b1;
          op_nxt   = cmd.op;
          res_nxt  = '{ran_kind: RAN_IDLE, ran_slot: 4'd0, late_flag: 1'b0,
                       tick_now: tick_r, error_code: ERR_OK};
          state_nxt = S_OUT;
          unique case (cmd.op)
            OP_TICK: begin
              found_nxt = 1'b0;
              best_nxt  = '0;
              idx_nxt   = '0;
              state_nxt = (n_act == '0) ? S_RUN : S_SCAN;
            end
            OP_LOAD: begin
              if (32'(cmd.task_slot) < MAX_TASKS) begin
                period_nxt[cmd.task_slot[TASK_W-1:0]] = cmd.period_ticks;
                work_nxt[cmd.task_slot[TASK_W-1:0]]   = cmd.work_ticks;
                dl_nxt[cmd.task_slot[TASK_W-1:0]]     = cmd.deadline_ticks;
                pend_nxt[cmd.task_slot[TASK_W-1:0]]   = PEND_W'(cmd.work_ticks);
                phase_nxt[cmd.task_slot[TASK_W-1:0]]  = '0;
              end
            end
            OP_SUBMIT: begin
              if (32'(qcnt_r) >= APER_DEPTH) begin
                res_nxt.error_code = ERR_FULL;
              end else if (qcnt_r != '0 && cmd.arrival_tick < last_arr_r) begin
                res_nxt.error_code = ERR_ORDER;
              end else begin
                arr_we       = 1'b1;
                rem_we       = 1'b1;
                last_arr_nxt = cmd.arrival_tick;
                qcnt_nxt     = qcnt_r + QCNT_W'(1);
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // new phase is (t+1) mod period, then keep the shortest pending period
        phase_nxt[ti] = (ph_inc >= {1'b0, period_r[ti]}) ? '0 : ph_inc[TIME_BITS-1:0];
        if (pend_r[ti] != '0 && (!found_r || period_r[ti] < best_per_r)) begin
          found_nxt    = 1'b1;
          best_nxt     = ti;
          best_per_nxt = period_r[ti];
        end
        idx_nxt = idx_r + TCNT_W'(1);
        if (last_idx) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (found_r) begin
          pend_nxt[best_r]  = pend_dec;
          res_nxt.ran_kind  = RAN_PER;
          res_nxt.ran_slot  = 4'(best_r);
          res_nxt.late_flag = (pend_dec != '0) && (phase_r[best_r] > dl_r[best_r]);
        end else if (qcnt_r != '0 && rd_arr_r <= tick_r) begin
          res_nxt.ran_kind = RAN_APER;
          res_nxt.ran_slot = 4'(head_r);
          if (rd_rem_r <= TIME_BITS'(1)) begin
            head_nxt = head_r + QPTR_W'(1);
            qcnt_nxt = qcnt_r - QCNT_W'(1);
          end else begin
            rem_we   = 1'b1;
            rem_addr = head_r;
            rem_wd   = rd_rem_r - TIME_BITS'(1);
          end
        end
        idx_nxt   = '0;
        state_nxt = (tick_r != '0 && n_act != '0) ? S_REL : S_OUT;
      end
      S_REL: begin
        if (phase_r[ti] == '0) begin
          pend_nxt[ti] = pend_sum[PEND_W] ? {PEND_W{1'b1}} : pend_sum[PEND_W-1:0];
        end
        idx_nxt = idx_r + TCNT_W'(1);
        if (last_idx) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_vld_r || res_pop) begin
          out_nxt     = res_r;
          out_vld_nxt = 1'b1;
          if (op_r == OP_TICK) begin
            tick_nxt = tick_r + TIME_BITS'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
      tick_r    <= '0;
      head_r    <= '0;
      qcnt_r    <= '0;
      found_r   <= 1'b0;
      idx_r     <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        pend_r[i]  <= '0;
        phase_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      tick_r    <= tick_nxt;
      head_r    <= head_nxt;
      qcnt_r    <= qcnt_nxt;
      found_r   <= found_nxt;
      idx_r     <= idx_nxt;
      pend_r    <= pend_nxt;
      phase_r   <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    best_r     <= best_nxt;
    best_per_r <= best_per_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
    last_arr_r <= last_arr_nxt;
    period_r   <= period_nxt;
    work_r     <= work_nxt;
    dl_r       <= dl_nxt;
  end

  always_ff @(posedge clk) begin
    if (arr_we) begin
      arr_mem[arr_addr] <= arr_wd;
    end
    rd_arr_r <= arr_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[rem_addr] <= rem_wd;
    end
    rd_rem_r <= rem_mem[head_r];
  end

  a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(qcnt_r) <= APER_DEPTH)
    else $error("job queue count beyond depth");

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> state_r == S_IDLE)
    else $error("command taken while busy");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && (!out_vld_r || res_pop)) |=> out_vld_r && state_r == S_IDLE)
    else $error("result not delivered to output register");

  a_late_per: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.late_flag |-> out_r.ran_kind == RAN_PER)
    else $error("late flag on a non periodic result");

endmodule

/* design/rate_monotonic_background_scheduler.sv */
// Rate monotonic scheduler with background service of aperiodic jobs. Words
// enter a two-word queue and are executed one at a time by the back end.
// A load or submit word passes through the idle and output states of the back end.
// A tick word makes a pass over the N slots in use (at most 8) that advances phases
// and picks the shortest pending period, runs the chosen job in a run step, makes a
// second pass that releases tasks whose period has come around, and hands the result
// to the output register in an output step. While the tick counter reads zero there
// is no release pass.
// A one-word output register lets the next word start while a result waits
// to be popped; the back end stalls only when that word is also done.
// Queue order of submitted jobs must follow arrival time.
module rate_monotonic_background_scheduler import rmbs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  in_word_t         in_word,
  input  logic             push,
  output logic             full,
  output out_word_t        out_word,
  output logic             empty,
  input  logic             pop,
  input  logic             cfg_we,
  input  logic [ACT_W-1:0] cfg_wdata
);

  cmd_t             cmd;
  logic             cmd_vld;
  logic             cmd_take;
  logic             res_vld;
  logic [ACT_W-1:0] active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  rmbs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .push     (push),
    .full     (full),
    .cmd      (cmd),
    .cmd_vld  (cmd_vld),
    .cmd_take (cmd_take)
  );

  rmbs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cmd_vld      (cmd_vld),
    .cmd_take     (cmd_take),
    .active_tasks (active_r),
    .res_word     (out_word),
    .res_vld      (res_vld),
    .res_pop      (pop)
  );

  assign empty = !res_vld;

endmodule

/* tb/testbench.sv */
// self-checking testbench of the rate monotonic scheduler with background server
module testbench;
  import rmbs_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  in_word_t  in_word = '0;
  logic      push = 1'b0;
  logic      full;
  out_word_t out_word;
  logic      empty;
  logic      pop = 1'b0;
  logic      cfg_we = 1'b0;
  logic [ACT_W-1:0] cfg_wdata = '0;

  rate_monotonic_background_scheduler dut (
    .clk(clk), .rst_n(rst_n), .in_word(in_word), .push(push), .full(full),
    .out_word(out_word), .empty(empty), .pop(pop),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [ACT_W-1:0]  sch_active;
  logic [15:0]       sch_period [MAX_TASKS];
  logic [15:0]       sch_work [MAX_TASKS];
  logic [15:0]       sch_deadline [MAX_TASKS];
  logic [PEND_W-1:0] sch_pending [MAX_TASKS];
  logic [15:0]       sch_phase [MAX_TASKS];
  logic [15:0]       aq_arrival [APER_DEPTH];
  logic [15:0]       aq_left [APER_DEPTH];
  logic [QPTR_W-1:0] aq_head;
  logic [QCNT_W-1:0] aq_count;
  logic [15:0]       sch_tick;

  in_word_t  word_q [$];
  out_word_t sched_q [$];
  int        fails = 0;
  int        n_tick = 0, n_per = 0, n_aper = 0, n_late = 0, n_full = 0, n_order = 0;
  int        idle_pct = 32;
  int        cyc = 0;

  // generator side estimate, keeps most arrivals in order and near the clock
  int        gen_tick = 0;
  int        gen_arr = 0;

  function automatic out_word_t sched_step(in_word_t w);
    out_word_t r;
    int n, best;
    bit found;
    logic [QPTR_W-1:0] q;
    logic [16:0] ph;
    logic [PEND_W:0] sum;
    r = '0;
    r.tick_now = sch_tick;
    n = (sch_active > MAX_TASKS) ? MAX_TASKS : int'(sch_active);
    if (w.req_type == REQ_LOAD) begin
      sch_period[w.task_slot] = w.period_ticks;
      sch_work[w.task_slot] = w.work_ticks;
      sch_deadline[w.task_slot] = w.deadline_ticks;
      sch_pending[w.task_slot] = PEND_W'(w.work_ticks);
      sch_phase[w.task_slot] = '0;
    end else if (w.req_type == REQ_SUBMIT) begin
      if (aq_count >= APER_DEPTH) begin
        r.error_code = ERR_FULL;
      end else if (aq_count > 0 &&
                   w.arrival_tick < aq_arrival[QPTR_W'(aq_head + aq_count - 1)]) begin
        r.error_code = ERR_ORDER;
      end else begin
        q = QPTR_W'(aq_head + aq_count);
        aq_arrival[q] = w.arrival_tick;
        aq_left[q] = w.work_ticks;
        aq_count++;
      end
    end else if (w.req_type == REQ_TICK) begin
      found = 0;
      best = 0;
      for (int i = 0; i < n; i++) begin
        ph = sch_phase[i] + 17'd1;
        if (ph >= sch_period[i]) ph = '0;
        sch_phase[i] = ph[15:0];
      end
      for (int i = 0; i < n; i++) begin
        if (sch_pending[i] != 0 && (!found || sch_period[i] < sch_period[best])) begin
          best = i;
          found = 1;
        end
      end
      if (found) begin
        r.ran_kind = RAN_PER;
        r.ran_slot = 4'(best);
        sch_pending[best]--;
        if (sch_pending[best] > 0 && sch_phase[best] > sch_deadline[best])
          r.late_flag = 1'b1;
      end else if (aq_count > 0 && aq_arrival[aq_head] <= sch_tick) begin
        r.ran_kind = RAN_APER;
        r.ran_slot = 4'(aq_head);
        if (aq_left[aq_head] <= 1) begin
          aq_left[aq_head] = '0;
          aq_head++;
          aq_count--;
        end else begin
          aq_left[aq_head]--;
        end
      end
      if (sch_tick != 0) begin
        for (int i = 0; i < n; i++) begin
          if (sch_phase[i] == 0) begin
            sum = sch_pending[i] + sch_work[i];
            sch_pending[i] = sum[PEND_W] ? {PEND_W{1'b1}} : sum[PEND_W-1:0];
          end
        end
      end
      sch_tick++;
    end
    return r;
  endfunction

  // driver: the word on in_word is taken when full is low
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) sched_q = {sched_q, sched_step(in_word)};
      if (!push || !full) begin
        if (word_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_word <= word_q.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        if (sched_q.size() == 0) begin
          $error("result word with nothing expected: %p", out_word);
          fails++;
        end else begin
          out_word_t e;
          e = sched_q.pop_front();
          if (out_word.ran_kind != e.ran_kind) begin
            $error("ran_kind expected %0d actual %0d", e.ran_kind, out_word.ran_kind);
            fails++;
          end
          if (out_word.ran_slot != e.ran_slot) begin
            $error("ran_slot expected %0d actual %0d", e.ran_slot, out_word.ran_slot);
            fails++;
          end
          if (out_word.late_flag != e.late_flag) begin
            $error("late_flag expected %0d actual %0d", e.late_flag, out_word.late_flag);
            fails++;
          end
          if (out_word.tick_now != e.tick_now) begin
            $error("tick_now expected %0d actual %0d", e.tick_now, out_word.tick_now);
            fails++;
          end
          if (out_word.error_code != e.error_code) begin
            $error("error_code expected %0d actual %0d", e.error_code, out_word.error_code);
            fails++;
          end
          n_per += (e.ran_kind == RAN_PER);
          n_aper += (e.ran_kind == RAN_APER);
          n_late += e.late_flag;
          n_full += (e.error_code == ERR_FULL);
          n_order += (e.error_code == ERR_ORDER);
        end
      end
      pop <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic in_word_t mk(logic [1:0] req, logic [2:0] slot, int per, int work,
                                  int dl, int arr);
    in_word_t w;
    w.req_type = req;
    w.task_slot = slot;
    w.period_ticks = 16'(per);
    w.work_ticks = 16'(work);
    w.deadline_ticks = 16'(dl);
    w.arrival_tick = 16'(arr);
    if (req == REQ_TICK) gen_tick++;
    return w;
  endfunction

  // one random word; sparse keeps periodic load light so the background server runs
  function automatic in_word_t rand_word(bit sparse);
    in_word_t w;
    logic [95:0] raw;
    int r;
    r = $urandom_range(99);
    if (r < 6) begin
      raw = {$urandom, $urandom, $urandom};
      w = raw[$bits(in_word_t)-1:0];
      if (w.req_type == REQ_TICK) gen_tick++;
    end else if (r < 14) begin
      w = mk(REQ_LOAD, 3'($urandom_range(7)),
             sparse ? $urandom_range(10, 40) : $urandom_range(0, 20),
             sparse ? $urandom_range(0, 2) : $urandom_range(0, 5),
             $urandom_range(0, 20), $urandom);
    end else if (r < 40) begin
      if ($urandom_range(9) == 0) begin
        w = mk(REQ_SUBMIT, 3'($urandom), $urandom, $urandom_range(0, 4), $urandom,
               gen_arr - $urandom_range(1, 5));
      end else begin
        gen_arr = (gen_arr < gen_tick - 5) ? gen_tick + $urandom_range(0, 3)
                                           : gen_arr + $urandom_range(0, 3);
        w = mk(REQ_SUBMIT, 3'($urandom), $urandom, $urandom_range(0, 4), $urandom,
               gen_arr);
      end
    end else if (r < 41) begin
      w = mk(2'd3, 3'($urandom), $urandom, $urandom, $urandom, $urandom);
    end else begin
      w = mk(REQ_TICK, 3'($urandom), $urandom, $urandom, $urandom, $urandom);
    end
    return w;
  endfunction

  task automatic drain(int extra);
    while (word_q.size() > 0 || push || sched_q.size() > 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_active(int v);
    drain(30);
    cfg_we <= 1'b1;
    cfg_wdata <= ACT_W'(v);
    sch_active = ACT_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int acts [10] = '{0, 15, 8, 1, 1, 3, 0, 5, 2, 8};
    sch_active = '0;
    foreach (sch_pending[i]) begin
      sch_pending[i] = '0;
      sch_phase[i] = '0;
    end
    aq_head = '0;
    aq_count = '0;
    sch_tick = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every slot gets loaded before any is put in use
    word_q = {word_q, mk(REQ_LOAD, 3'd0, 65535, 65535, 65535, 65535)};
    word_q = {word_q, mk(REQ_LOAD, 3'd7, 0, 0, 0, 0)};
    for (int i = 1; i < 7; i++)
      word_q = {word_q, mk(REQ_LOAD, 3'(i), 2 + i, 1, 0, 0)};
    word_q = {word_q, mk(2'd3, 3'd7, 65535, 65535, 65535, 65535)};
    word_q = {word_q, mk(REQ_SUBMIT, 3'd0, 0, 0, 0, 0)};
    word_q = {word_q, mk(REQ_SUBMIT, 3'd0, 0, 65535, 0, 65535)};
    word_q = {word_q, mk(REQ_SUBMIT, 3'd0, 0, 1, 0, 4)};
    drain(5);
    set_active(8);
    for (int i = 0; i < 6; i++) word_q = {word_q, mk(REQ_TICK, 3'd0, 0, 0, 0, 0)};
    drain(5);
    // reload slot 0 so the background queue can drain in later phases
    word_q = {word_q, mk(REQ_LOAD, 3'd0, 9, 1, 3, 0)};
    gen_arr = 65535;

    for (int p = 0; p < 10; p++) begin
      set_active(p == 9 ? $urandom_range(0, 15) : acts[p]);
      idle_pct = (p == 2) ? 0 : 32;
      if (p == 4) begin
        // period one with maximum work drives pending work to saturation
        word_q = {word_q, mk(REQ_LOAD, 3'd0, 1, 65535, 0, 0)};
        for (int i = 0; i < 300; i++) word_q = {word_q, mk(REQ_TICK, 3'd0, 0, 0, 0, 0)};
        word_q = {word_q, mk(REQ_LOAD, 3'd0, 12, 1, 5, 0)};
      end else begin
        for (int i = 0; i < 175; i++)
          word_q = {word_q, rand_word(p == 3 || p == 5 || p == 7)};
      end
    end
    drain(40);
    $display("ticks %0d: periodic runs %0d, background runs %0d, late %0d", n_tick,
             n_per, n_aper, n_late);
    $display("submit rejects: queue full %0d, out of order %0d", n_full, n_order);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // count ticks as they are accepted
  always @(posedge clk) begin
    if (rst_n && push && !full && in_word.req_type == REQ_TICK) n_tick <= n_tick + 1;
  end

endmodule
